// ----- rtl/lmss_pkg.sv -----
// Shared types and constants for the LED matrix shift-register scanner.
// No dependencies; imported by every module of the block.
package lmss_pkg;

    // Matrix geometry
    localparam int ROWS = 8;
    localparam int COLS = 16;

    // Field and storage widths
    localparam int ROW_W   = 3;
    localparam int COL_W   = 4;
    localparam int ADDR_W  = $clog2(ROWS * COLS);
    localparam int DEPTH   = ROWS * COLS;
    localparam int RIDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SHIFT_W = $clog2((2 * COLS > ROWS + 2) ? 2 * COLS : ROWS + 2);
    localparam int TICK_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [TICK_W-1:0] PULSE_RST = 16'd1;
    localparam logic [TICK_W-1:0] LATCH_RST = 16'd1;
    localparam logic [TICK_W-1:0] HOLD_RST  = 16'd1000;

    // Scan phases of the pin waveform
    typedef enum logic [13:0] {
        PH_FR_SETUP = 14'b00000000000001,
        PH_FR_HIGH  = 14'b00000000000010,
        PH_FR_LOW   = 14'b00000000000100,
        PH_C_SETUP  = 14'b00000000001000,
        PH_C_HIGH   = 14'b00000000010000,
        PH_C_LOW    = 14'b00000000100000,
        PH_CL_HIGH  = 14'b00000001000000,
        PH_CL_LOW   = 14'b00000010000000,
        PH_RL_HIGH  = 14'b00000100000000,
        PH_RL_LOW   = 14'b00001000000000,
        PH_HOLD     = 14'b00010000000000,
        PH_RN_SETUP = 14'b00100000000000,
        PH_RN_HIGH  = 14'b01000000000000,
        PH_RN_LOW   = 14'b10000000000000
    } phase_t;

    // Levels of the six chain pins
    typedef struct packed {
        logic row_data;
        logic row_shift;
        logic row_latch;
        logic col_data;
        logic col_shift;
        logic col_latch;
    } pins_t;

    // Timing registers
    typedef struct packed {
        logic [TICK_W-1:0] pulse_ticks;
        logic [TICK_W-1:0] latch_ticks;
        logic [TICK_W-1:0] hold_ticks;
    } cfg_t;

    // Frame store access requests
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

    // Result held in the output register
    typedef struct packed {
        pins_t pins;
        logic  use_mem;
        logic  frame_end;
    } result_t;

endpackage

// ----- rtl/lmss_frame_store.sv -----
// Frame store: one-bit pixel memory with registered read and per-entry valid bits.
// Depends on lmss_pkg; an entry never written since reset reads as dark.
module lmss_frame_store
    import lmss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  store_wr_t wr,
    input  store_rd_t rd,
    output logic      pix
);

    logic              mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic              data_reg;
    logic              vld_reg;

    // Write the pixel array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read the pixel array; hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            data_reg <= mem[rd.addr];
        end
    end

    // Track written entries; reset marks the whole frame dark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (rd.en)
            begin
                vld_reg <= valid_reg[rd.addr];
            end
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    assign pix = vld_reg & data_reg;

endmodule

// ----- rtl/lmss_scan_ctrl.sv -----
// Scan sequencer: phase, row, shift and wait counters plus the chain pin levels.
// Depends on lmss_pkg; issues pixel reads to lmss_frame_store.
module lmss_scan_ctrl
    import lmss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tick_go,
    input  cfg_t      cfg,
    input  logic      pix,
    output store_rd_t rd,
    output pins_t     pins_live,
    output pins_t     pins_next,
    output logic      use_mem,
    output logic      frame_end
);

    phase_t              phase_reg, phase_next;
    logic [RIDX_W-1:0]   row_reg, row_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [TICK_W-1:0]   wait_reg, wait_next;
    pins_t               pins_reg, pins_upd;
    logic                col_pend_reg, col_pend_next;
    logic                col_data_reg, col_data_next;

    logic                legal;
    phase_t              ph;
    logic [RIDX_W-1:0]   row;
    logic [SHIFT_W-1:0]  sh;
    logic [TICK_W-1:0]   wt;
    logic [TICK_W-1:0]   len_raw;
    logic [TICK_W-1:0]   len;
    logic [TICK_W:0]     wsum;
    logic                done;
    logic [SHIFT_W:0]    sh_inc;
    logic                col_read;
    logic                live_col;
    logic [SHIFT_W:0]    col_sel;
    logic [ADDR_W-1:0]   rd_addr;

    // Resolve the column data pin of a read still in flight
    assign live_col = col_pend_reg ? ~pix : col_data_reg;

    always_comb
    begin
        pins_live          = pins_reg;
        pins_live.col_data = live_col;
    end

    // Check the stored phase; an unknown one restarts the frame
    always_comb
    begin
        case (phase_reg)
            PH_FR_SETUP, PH_FR_HIGH, PH_FR_LOW, PH_C_SETUP, PH_C_HIGH, PH_C_LOW,
            PH_CL_HIGH, PH_CL_LOW, PH_RL_HIGH, PH_RL_LOW, PH_HOLD,
            PH_RN_SETUP, PH_RN_HIGH, PH_RN_LOW: legal = 1'b1;
            default:                            legal = 1'b0;
        endcase
        if ((RIDX_W + 1)'(row_reg) >= (RIDX_W + 1)'(ROWS))
        begin
            legal = 1'b0;
        end
        ph  = legal ? phase_reg : PH_FR_SETUP;
        row = legal ? row_reg   : '0;
        sh  = legal ? shift_reg : '0;
        wt  = legal ? wait_reg  : '0;
    end

    // Pick the phase length; zero counts as one
    always_comb
    begin
        case (ph)
            PH_CL_HIGH, PH_CL_LOW, PH_RL_HIGH, PH_RL_LOW: len_raw = cfg.latch_ticks;
            PH_HOLD:                                      len_raw = cfg.hold_ticks;
            default:                                      len_raw = cfg.pulse_ticks;
        endcase
        len  = (len_raw == '0) ? TICK_W'(1) : len_raw;
        wsum = {1'b0, wt} + (TICK_W + 1)'(1);
        done = (wsum >= {1'b0, len});
    end

    // Pixel address: columns go out from the last one down to column 0
    assign col_read = (ph == PH_C_SETUP)
                   && ({1'b0, sh} >= (SHIFT_W + 1)'(COLS))
                   && ({1'b0, sh} <  (SHIFT_W + 1)'(2 * COLS));
    assign col_sel  = (SHIFT_W + 1)'(2 * COLS - 1) - {1'b0, sh};
    assign rd_addr  = ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col_sel);

    assign rd.en   = tick_go & col_read;
    assign rd.addr = rd_addr;
    assign use_mem = col_read;

    // Drive the pins for this tick
    always_comb
    begin
        pins_upd          = pins_live;
        case (ph)
            PH_FR_SETUP:
            begin
                pins_upd.row_latch = 1'b0;
                pins_upd.row_data  = ({1'b0, sh} >= (SHIFT_W + 1)'(ROWS));
            end
            PH_FR_HIGH, PH_RN_HIGH: pins_upd.row_shift = 1'b1;
            PH_FR_LOW, PH_RN_LOW:   pins_upd.row_shift = 1'b0;
            PH_C_SETUP:
            begin
                pins_upd.col_latch = 1'b0;
                if ({1'b0, sh} < (SHIFT_W + 1)'(COLS))
                begin
                    pins_upd.col_data = 1'b0;
                end
                else if (!col_read)
                begin
                    pins_upd.col_data = 1'b1;
                end
            end
            PH_C_HIGH:  pins_upd.col_shift = 1'b1;
            PH_C_LOW:   pins_upd.col_shift = 1'b0;
            PH_CL_HIGH: pins_upd.col_latch = 1'b1;
            PH_CL_LOW:  pins_upd.col_latch = 1'b0;
            PH_RL_HIGH: pins_upd.row_latch = 1'b1;
            PH_RL_LOW:  pins_upd.row_latch = 1'b0;
            PH_RN_SETUP:
            begin
                pins_upd.row_latch = 1'b0;
                pins_upd.row_data  = 1'b0;
            end
            default:    pins_upd = pins_live;
        endcase
        pins_next = pins_upd;
    end

    // Advance the phase when its wait runs out
    always_comb
    begin
        phase_next = ph;
        row_next   = row;
        shift_next = sh;
        wait_next  = wsum[TICK_W-1:0];
        frame_end  = 1'b0;
        sh_inc     = {1'b0, sh} + (SHIFT_W + 1)'(1);
        if (done)
        begin
            wait_next = '0;
            case (ph)
                PH_FR_SETUP: phase_next = PH_FR_HIGH;
                PH_FR_HIGH:  phase_next = PH_FR_LOW;
                PH_FR_LOW:
                begin
                    if (sh_inc <= (SHIFT_W + 1)'(ROWS))
                    begin
                        shift_next = sh_inc[SHIFT_W-1:0];
                        phase_next = PH_FR_SETUP;
                    end
                    else
                    begin
                        shift_next = '0;
                        phase_next = PH_C_SETUP;
                    end
                end
                PH_C_SETUP:  phase_next = PH_C_HIGH;
                PH_C_HIGH:   phase_next = PH_C_LOW;
                PH_C_LOW:
                begin
                    if (sh_inc < (SHIFT_W + 1)'(2 * COLS))
                    begin
                        shift_next = sh_inc[SHIFT_W-1:0];
                        phase_next = PH_C_SETUP;
                    end
                    else
                    begin
                        shift_next = '0;
                        phase_next = PH_CL_HIGH;
                    end
                end
                PH_CL_HIGH:  phase_next = PH_CL_LOW;
                PH_CL_LOW:   phase_next = PH_RL_HIGH;
                PH_RL_HIGH:  phase_next = PH_RL_LOW;
                PH_RL_LOW:   phase_next = PH_HOLD;
                PH_HOLD:     phase_next = PH_RN_SETUP;
                PH_RN_SETUP: phase_next = PH_RN_HIGH;
                PH_RN_HIGH:  phase_next = PH_RN_LOW;
                PH_RN_LOW:
                begin
                    shift_next = '0;
                    if ((RIDX_W + 1)'(row) >= (RIDX_W + 1)'(ROWS - 1))
                    begin
                        row_next   = '0;
                        phase_next = PH_FR_SETUP;
                        frame_end  = 1'b1;
                    end
                    else
                    begin
                        row_next   = row + RIDX_W'(1);
                        phase_next = PH_C_SETUP;
                    end
                end
                default:     phase_next = PH_FR_SETUP;
            endcase
        end
    end

    // Fold a finished read into the column data level
    assign col_pend_next = tick_go & col_read;
    assign col_data_next = tick_go ? pins_upd.col_data : live_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FR_SETUP;
            row_reg      <= '0;
            shift_reg    <= '0;
            wait_reg     <= '0;
            pins_reg     <= '0;
            col_pend_reg <= 1'b0;
            col_data_reg <= 1'b0;
        end
        else
        begin
            col_pend_reg <= col_pend_next;
            col_data_reg <= col_data_next;
            if (tick_go)
            begin
                phase_reg <= phase_next;
                row_reg   <= row_next;
                shift_reg <= shift_next;
                wait_reg  <= wait_next;
                pins_reg  <= pins_upd;
            end
        end
    end

endmodule

// ----- rtl/led_matrix_shift_register_scanner_unit.sv -----
// Top level of the LED matrix scanner: handshake, timing registers, output register.
// Depends on lmss_pkg, lmss_frame_store and lmss_scan_ctrl.
//
// Each accepted item is either a tick that advances the row and column chain waveform by
// one step or a pixel write into the 8 x 16 frame store; every item yields one result with
// the six pin levels and the frame-end flag. The block takes one item per clock unless its
// full output register is stalled: state is updated in the cycle of the transfer and the
// result sits in one output register, which is refilled in the same cycle it is taken;
// the result appears in the cycle after its input transfer. In the pixel half of a column
// shift, the pixel is read from the frame store on every tick of the setup phase; the
// store's registered read port resolves the column data pin in the cycle after, so writes
// land in order with ticks. The store reads dark after reset without any clearing pass.
// Timing registers take effect on the next tick; a value of zero counts as one.
module led_matrix_shift_register_scanner_unit
    import lmss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [ROW_W-1:0]     pixel_row,
    input  logic [COL_W-1:0]     pixel_col,
    input  logic                 pixel_on,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 row_data,
    output logic                 row_shift,
    output logic                 row_latch,
    output logic                 col_data,
    output logic                 col_shift,
    output logic                 col_latch,
    output logic                 frame_end
);

    cfg_t      cfg_reg;
    logic      out_valid_reg, out_valid_next;
    result_t   res_reg;
    result_t   res_next;
    logic      accept;
    logic      tick_go;
    store_wr_t wr;
    store_rd_t rd;
    logic      pix;
    pins_t     pins_live;
    pins_t     pins_next;
    logic      use_mem;
    logic      fe;

    // Take a transfer whenever the output register is free or being emptied
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign tick_go  = accept & ~cmd;

    // Write pixels inside the matrix only
    always_comb
    begin
        wr.en   = accept & cmd
                & ((ROW_W + 1)'(pixel_row) < (ROW_W + 1)'(ROWS))
                & ((COL_W + 1)'(pixel_col) < (COL_W + 1)'(COLS));
        wr.addr = ADDR_W'(pixel_row) * ADDR_W'(COLS) + ADDR_W'(pixel_col);
        wr.data = pixel_on;
    end

    lmss_frame_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .pix   (pix)
    );

    lmss_scan_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_go   (tick_go),
        .cfg       (cfg_reg),
        .pix       (pix),
        .rd        (rd),
        .pins_live (pins_live),
        .pins_next (pins_next),
        .use_mem   (use_mem),
        .frame_end (fe)
    );

    // Hold the timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_ticks <= PULSE_RST;
            cfg_reg.latch_ticks <= LATCH_RST;
            cfg_reg.hold_ticks  <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PULSE: cfg_reg.pulse_ticks <= cfg_wdata;
                CFG_LATCH: cfg_reg.latch_ticks <= cfg_wdata;
                CFG_HOLD:  cfg_reg.hold_ticks  <= cfg_wdata;
                default:   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Build the result: a tick shows the new pins, a write the current ones
    always_comb
    begin
        if (cmd)
        begin
            res_next.pins      = pins_live;
            res_next.use_mem   = 1'b0;
            res_next.frame_end = 1'b0;
        end
        else
        begin
            res_next.pins      = pins_next;
            res_next.use_mem   = use_mem;
            res_next.frame_end = fe;
        end
    end

    assign out_valid_next = accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // Drive the result; a pending pixel comes straight from the store read port
    assign out_valid = out_valid_reg;
    assign row_data  = res_reg.pins.row_data;
    assign row_shift = res_reg.pins.row_shift;
    assign row_latch = res_reg.pins.row_latch;
    assign col_data  = res_reg.use_mem ? ~pix : res_reg.pins.col_data;
    assign col_shift = res_reg.pins.col_shift;
    assign col_latch = res_reg.pins.col_latch;
    assign frame_end = res_reg.frame_end;

endmodule

// ----- verif/tb_led_matrix_shift_register_scanner_unit.sv -----
// Self-checking testbench for the LED matrix scanner: random tick and pixel-write traffic
// with bursty valid and stall, checked pin by pin against an in-bench scan predictor.
// Depends on lmss_pkg and led_matrix_shift_register_scanner_unit.
module tb_led_matrix_shift_register_scanner_unit;
    import lmss_pkg::*;

    localparam logic CMD_TICK      = 1'b0;
    localparam logic CMD_WRITE     = 1'b1;
    localparam int   CYCLE_LIMIT   = 300000;
    localparam int   SETTLE_CYCLES = 4;
    localparam int   MAX_PRINTS    = 40;

    typedef struct packed {
        logic             cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             lit;
    } scan_item_t;

    typedef struct packed {
        pins_t pins;
        logic  frame_end;
    } pin_sample_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PULSE;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 cmd = CMD_TICK;
    logic [ROW_W-1:0]     pixel_row = '0;
    logic [COL_W-1:0]     pixel_col = '0;
    logic                 pixel_on = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 row_data;
    logic                 row_shift;
    logic                 row_latch;
    logic                 col_data;
    logic                 col_shift;
    logic                 col_latch;
    logic                 frame_end;

    scan_item_t  pending_items[$];
    pin_sample_t pin_expect[$];
    scan_item_t  driven_item;
    int          in_gap = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b1;
    int          cycle_count = 0;
    int          mismatch_count = 0;

    // Scan predictor state
    bit          px_store [DEPTH];
    phase_t      scan_ph;
    int unsigned row_idx;
    int unsigned shift_cnt;
    int unsigned wait_cnt;
    pins_t       pin_lv;
    logic [15:0] pulse_len;
    logic [15:0] latch_len;
    logic [15:0] hold_len;

    led_matrix_shift_register_scanner_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .pixel_row (pixel_row),
        .pixel_col (pixel_col),
        .pixel_on  (pixel_on),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_data  (row_data),
        .row_shift (row_shift),
        .row_latch (row_latch),
        .col_data  (col_data),
        .col_shift (col_shift),
        .col_latch (col_latch),
        .frame_end (frame_end)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_pin(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s got %b want %b", name, got, want));
    endtask

    task automatic clear_scan_state();
        foreach (px_store[i])
            px_store[i] = 1'b0;
        scan_ph   = PH_FR_SETUP;
        row_idx   = 0;
        shift_cnt = 0;
        wait_cnt  = 0;
        pin_lv    = '0;
        pulse_len = PULSE_RST;
        latch_len = LATCH_RST;
        hold_len  = HOLD_RST;
    endtask

    function automatic int unsigned phase_ticks(phase_t ph);
        logic [15:0] v;
        case (ph)
            PH_CL_HIGH, PH_CL_LOW, PH_RL_HIGH, PH_RL_LOW: v = latch_len;
            PH_HOLD: v = hold_len;
            default: v = pulse_len;
        endcase
        return (v == 16'd0) ? 1 : int'(v);
    endfunction

    // Apply one item to the scan state and return the pin levels it leaves behind
    task automatic advance_scan(input scan_item_t it, output pin_sample_t res);
        logic fe;
        fe = 1'b0;
        if (it.cmd == CMD_WRITE)
        begin
            px_store[int'(it.row) * COLS + int'(it.col)] = it.lit;
        end
        else
        begin
            // drive the pins of the current phase
            case (scan_ph)
                PH_FR_SETUP:
                begin
                    pin_lv.row_latch = 1'b0;
                    pin_lv.row_data  = (shift_cnt >= ROWS);
                end
                PH_FR_HIGH, PH_RN_HIGH: pin_lv.row_shift = 1'b1;
                PH_FR_LOW, PH_RN_LOW:   pin_lv.row_shift = 1'b0;
                PH_C_SETUP:
                begin
                    pin_lv.col_latch = 1'b0;
                    if (shift_cnt < COLS)
                        pin_lv.col_data = 1'b0;
                    else
                        pin_lv.col_data = !px_store[row_idx * COLS + (2 * COLS - 1 - shift_cnt)];
                end
                PH_C_HIGH:  pin_lv.col_shift = 1'b1;
                PH_C_LOW:   pin_lv.col_shift = 1'b0;
                PH_CL_HIGH: pin_lv.col_latch = 1'b1;
                PH_CL_LOW:  pin_lv.col_latch = 1'b0;
                PH_RL_HIGH: pin_lv.row_latch = 1'b1;
                PH_RL_LOW:  pin_lv.row_latch = 1'b0;
                PH_RN_SETUP:
                begin
                    pin_lv.row_latch = 1'b0;
                    pin_lv.row_data  = 1'b0;
                end
                default: ;
            endcase

            // count the tick and step to the next phase when it runs out
            wait_cnt++;
            if (wait_cnt >= phase_ticks(scan_ph))
            begin
                wait_cnt = 0;
                case (scan_ph)
                    PH_FR_LOW:
                    begin
                        shift_cnt++;
                        if (shift_cnt <= ROWS)
                            scan_ph = PH_FR_SETUP;
                        else
                        begin
                            shift_cnt = 0;
                            scan_ph   = PH_C_SETUP;
                        end
                    end
                    PH_C_LOW:
                    begin
                        shift_cnt++;
                        if (shift_cnt < 2 * COLS)
                            scan_ph = PH_C_SETUP;
                        else
                        begin
                            shift_cnt = 0;
                            scan_ph   = PH_CL_HIGH;
                        end
                    end
                    PH_RN_LOW:
                    begin
                        shift_cnt = 0;
                        if (row_idx >= ROWS - 1)
                        begin
                            row_idx = 0;
                            scan_ph = PH_FR_SETUP;
                            fe      = 1'b1;
                        end
                        else
                        begin
                            row_idx++;
                            scan_ph = PH_C_SETUP;
                        end
                    end
                    PH_FR_SETUP: scan_ph = PH_FR_HIGH;
                    PH_FR_HIGH:  scan_ph = PH_FR_LOW;
                    PH_C_SETUP:  scan_ph = PH_C_HIGH;
                    PH_C_HIGH:   scan_ph = PH_C_LOW;
                    PH_CL_HIGH:  scan_ph = PH_CL_LOW;
                    PH_CL_LOW:   scan_ph = PH_RL_HIGH;
                    PH_RL_HIGH:  scan_ph = PH_RL_LOW;
                    PH_RL_LOW:   scan_ph = PH_HOLD;
                    PH_HOLD:     scan_ph = PH_RN_SETUP;
                    PH_RN_SETUP: scan_ph = PH_RN_HIGH;
                    PH_RN_HIGH:  scan_ph = PH_RN_LOW;
                    default:     scan_ph = PH_FR_SETUP;
                endcase
            end
        end
        res.pins      = pin_lv;
        res.frame_end = fe;
    endtask

    function automatic void queue_item(logic c, int r, int col, logic lit);
        scan_item_t it;
        it.cmd = c;
        it.row = ROW_W'(r);
        it.col = COL_W'(col);
        it.lit = lit;
        pending_items.push_back(it);
    endfunction

    // Mostly ticks so the waveform runs deep, with pixel writes mixed in
    function automatic void queue_random(int count, int tick_pct);
        for (int i = 0; i < count; i++)
            queue_item(($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_WRITE,
                       $urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                       1'($urandom_range(1)));
    endfunction

    // Wait until every queued item has been transferred and answered
    task automatic drain_scanner();
        while (pending_items.size() != 0 || in_valid || pin_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timing(input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] latch,
                                input logic [CFG_W-1:0] hold);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PULSE;
        cfg_wdata <= pulse;
        @(posedge clk);
        cfg_index <= CFG_LATCH;
        cfg_wdata <= latch;
        @(posedge clk);
        cfg_index <= CFG_HOLD;
        cfg_wdata <= hold;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pulse_len = pulse;
        latch_len = latch;
        hold_len  = hold;
    endtask

    // Input side: record each transfer, then present the next item or idle
    always @(posedge clk)
    begin : item_drive
        pin_sample_t predicted;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_scan(driven_item, predicted);
                pin_expect.push_back(predicted);
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap--;
                end
                else if (pending_items.size() != 0)
                begin
                    driven_item = pending_items.pop_front();
                    cmd       <= driven_item.cmd;
                    pixel_row <= driven_item.row;
                    pixel_col <= driven_item.col;
                    pixel_on  <= driven_item.lit;
                    in_valid  <= 1'b1;
                    if (idle_on && $urandom_range(9) == 0)
                        in_gap = $urandom_range(1, 11);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (idle_on && $urandom_range(9) == 0)
                    stall_left = $urandom_range(1, 11);
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : result_check
        pin_sample_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pin_expect.size() == 0)
                report_mismatch("result with no prediction pending");
            else
            begin
                want = pin_expect.pop_front();
                check_pin("row_data", row_data, want.pins.row_data);
                check_pin("row_shift", row_shift, want.pins.row_shift);
                check_pin("row_latch", row_latch, want.pins.row_latch);
                check_pin("col_data", col_data, want.pins.col_data);
                check_pin("col_shift", col_shift, want.pins.col_shift);
                check_pin("col_latch", col_latch, want.pins.col_latch);
                check_pin("frame_end", frame_end, want.frame_end);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        clear_scan_state();

        // Directed: store corners, both pixel values, ticks at reset timing
        queue_item(CMD_TICK, 0, 0, 1'b0);
        queue_item(CMD_TICK, 0, 0, 1'b0);
        queue_item(CMD_WRITE, 0, 0, 1'b1);
        queue_item(CMD_WRITE, 7, 15, 1'b1);
        queue_item(CMD_WRITE, 7, 0, 1'b1);
        queue_item(CMD_WRITE, 0, 15, 1'b1);
        queue_item(CMD_TICK, 7, 15, 1'b1);
        queue_item(CMD_WRITE, 0, 15, 1'b0);
        queue_item(CMD_TICK, 0, 0, 1'b0);
        queue_item(CMD_TICK, 3, 9, 1'b1);
        queue_item(CMD_WRITE, 5, 10, 1'b1);
        queue_item(CMD_WRITE, 2, 5, 1'b0);
        for (int i = 0; i < 4; i++)
            queue_item(CMD_TICK, 0, 0, 1'b0);
        queue_item(CMD_WRITE, 7, 15, 1'b0);
        queue_item(CMD_WRITE, 3, 9, 1'b1);
        for (int i = 0; i < 4; i++)
            queue_item(CMD_TICK, 7, 15, 1'b1);
        drain_scanner();

        // Fastest timing, then zero values that must act as one
        write_timing(16'd1, 16'd1, 16'd1);
        queue_random(600, 88);
        drain_scanner();
        write_timing(16'd0, 16'd0, 16'd0);
        queue_random(450, 88);
        drain_scanner();

        // Stretched phases
        write_timing(16'd3, 16'd2, 16'd4);
        queue_random(250, 85);
        drain_scanner();

        // Longest timing: the waveform barely moves
        write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(30, 70);
        drain_scanner();

        // Closing stretch at full rate, no idling
        idle_on = 1'b0;
        write_timing(16'd1, 16'd2, 16'd1);
        queue_random(200, 88);
        drain_scanner();

        if (pin_expect.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pin_expect.size()));
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
